[hw/rtl/sdw_pkg.sv]
// ----------------------------------------------------------------------------
// sdw_pkg
// Shared types, constants and the segment table for the digit write serializer.
// ----------------------------------------------------------------------------
package sdw_pkg;

    // Number of digit grids on the display
    localparam logic [4:0] NUM_GRIDS = 5'd16;

    // Default depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Fixed protocol bytes
    localparam logic [7:0] CMD_FIXED_WRITE = 8'h44;
    localparam logic [7:0] ADDR_BASE       = 8'hC0;
    localparam logic [7:0] CTRL_RESET      = 8'h8F;
    localparam logic [7:0] SEG_BLANK       = 8'h00;
    localparam logic [7:0] SEG_MINUS       = 8'h40;
    localparam logic [7:0] SEG_POINT       = 8'h80;

    // Index of the final symbol of a request (38 symbols in all)
    localparam logic [5:0] SYM_LAST_IDX = 6'd37;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_RAW   = 2'd0,
        OP_HEX   = 2'd1,
        OP_BLANK = 2'd2,
        OP_MINUS = 2'd3
    } sdw_op_t;

    // Line symbol kinds
    typedef enum logic [1:0] {
        SYM_START = 2'd0,
        SYM_BIT   = 2'd1,
        SYM_STOP  = 2'd2
    } sdw_sym_t;

    // One decoded digit write, queued between front and back
    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] seg;
    } sdw_cmd_t;

    // Seven-segment pattern for a hex digit
    function automatic logic [7:0] seg_lookup(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'h0:    seg = 8'h3F;
            4'h1:    seg = 8'h06;
            4'h2:    seg = 8'h5B;
            4'h3:    seg = 8'h4F;
            4'h4:    seg = 8'h66;
            4'h5:    seg = 8'h6D;
            4'h6:    seg = 8'h7D;
            4'h7:    seg = 8'h07;
            4'h8:    seg = 8'h7F;
            4'h9:    seg = 8'h6F;
            4'hA:    seg = 8'h77;
            4'hB:    seg = 8'h7C;
            4'hC:    seg = 8'h39;
            4'hD:    seg = 8'h5E;
            4'hE:    seg = 8'h79;
            default: seg = 8'h71;
        endcase
        return seg;
    endfunction

endpackage

[hw/rtl/sdw_front.sv]
// ----------------------------------------------------------------------------
// sdw_front
// Accepts digit write requests, checks the grid number and builds the
// address and segment bytes for the queue.
// ----------------------------------------------------------------------------
module sdw_front (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,    // position[4:0], value[12:5], with_point[13]
    input  logic [1:0]          s_tuser,    // op[1:0]
    input  logic                q_ready,
    output logic                q_push,
    output sdw_pkg::sdw_cmd_t   q_cmd
);

    logic [4:0]       position;
    logic [7:0]       value;
    logic             with_point;
    sdw_pkg::sdw_op_t op;
    logic             in_range;
    logic [7:0]       seg;

    assign position   = s_tdata[4:0];
    assign value      = s_tdata[12:5];
    assign with_point = s_tdata[13];
    assign op         = sdw_pkg::sdw_op_t'(s_tuser);

    // Out-of-range grid numbers are taken and dropped
    assign in_range = (position != 5'd0) && (position <= sdw_pkg::NUM_GRIDS);

    // Segment byte by opcode
    always_comb
    begin
        case (op)
            sdw_pkg::OP_RAW:   seg = value;
            sdw_pkg::OP_HEX:   seg = sdw_pkg::seg_lookup(value[3:0])
                                     | (with_point ? sdw_pkg::SEG_POINT : 8'h00);
            sdw_pkg::OP_BLANK: seg = sdw_pkg::SEG_BLANK;
            default:           seg = sdw_pkg::SEG_MINUS;
        endcase
    end

    assign q_cmd.seg  = seg;
    assign q_cmd.addr = sdw_pkg::ADDR_BASE + {3'b000, position} - 8'd1;

    // Transfer handshake
    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready && in_range;

endmodule

[hw/rtl/sdw_queue.sv]
// ----------------------------------------------------------------------------
// sdw_queue
// Small first-in first-out queue of decoded digit writes.
// ----------------------------------------------------------------------------
module sdw_queue #(
    parameter int DEPTH = sdw_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sdw_pkg::sdw_cmd_t   push_cmd,
    output logic                not_full,
    input  logic                pop,
    output logic                not_empty,
    output sdw_pkg::sdw_cmd_t   head_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    sdw_pkg::sdw_cmd_t entries [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_full  = (count_reg != CNT_MAX);
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entries[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[hw/rtl/sdw_back.sv]
// ----------------------------------------------------------------------------
// sdw_back
// Serializes one queued digit write into 38 line symbols, one per cycle while
// the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module sdw_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  sdw_pkg::sdw_cmd_t   q_cmd,
    output logic                q_pop,
    input  logic [7:0]          display_control,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,    // bit_value[0]
    output logic [1:0]          m_tuser,    // symbol_kind[1:0]
    output logic                m_tlast
);

    logic [5:0]         idx_reg, idx_next;
    sdw_pkg::sdw_cmd_t  cmd_reg;
    logic               valid_reg, valid_next;
    sdw_pkg::sdw_sym_t  kind_reg, kind_next;
    logic               bit_reg, bit_next;
    logic               last_reg, last_next;

    logic               advance;
    logic               emit;
    logic [7:0]         cur_byte;
    logic [5:0]         bit_off;

    // Output register frees up when empty or taken
    assign advance = !valid_reg || m_tready;
    // A request starts only when one is queued; later symbols always go
    assign emit    = (idx_reg != 6'd0) || q_valid;
    assign q_pop   = advance && q_valid && (idx_reg == 6'd0);

    // Symbol decode by position in the request
    always_comb
    begin
        kind_next = sdw_pkg::SYM_BIT;
        cur_byte  = sdw_pkg::CMD_FIXED_WRITE;
        bit_off   = idx_reg - 6'd1;
        if (idx_reg == 6'd0 || idx_reg == 6'd10 || idx_reg == 6'd28)
        begin
            kind_next = sdw_pkg::SYM_START;
        end
        else if (idx_reg == 6'd9 || idx_reg == 6'd27 || idx_reg == sdw_pkg::SYM_LAST_IDX)
        begin
            kind_next = sdw_pkg::SYM_STOP;
        end
        else if (idx_reg < 6'd9)
        begin
            cur_byte = sdw_pkg::CMD_FIXED_WRITE;
            bit_off  = idx_reg - 6'd1;
        end
        else if (idx_reg < 6'd19)
        begin
            cur_byte = cmd_reg.addr;
            bit_off  = idx_reg - 6'd11;
        end
        else if (idx_reg < 6'd27)
        begin
            cur_byte = cmd_reg.seg;
            bit_off  = idx_reg - 6'd19;
        end
        else
        begin
            cur_byte = display_control;
            bit_off  = idx_reg - 6'd29;
        end
        bit_next  = (kind_next == sdw_pkg::SYM_BIT) ? cur_byte[bit_off[2:0]] : 1'b0;
        last_next = (idx_reg == sdw_pkg::SYM_LAST_IDX);
    end

    // Symbol counter and output valid
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = emit;
            if (emit)
            begin
                idx_next = (idx_reg == sdw_pkg::SYM_LAST_IDX) ? 6'd0 : idx_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 6'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (advance && emit)
        begin
            kind_reg <= kind_next;
            bit_reg  <= bit_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'b0000000, bit_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

[hw/rtl/segment_digit_write_serializer.sv]
// ----------------------------------------------------------------------------
// segment_digit_write_serializer
// Digit write requests in, two-wire LED driver line symbols out.
// ----------------------------------------------------------------------------
// Each request with a grid number from 1 to 16 produces 38 symbols: start,
// command 0x44, stop; start, address 0xC0 plus grid minus one, segment byte,
// stop; start, display control byte, stop. Bytes go out LSB first and the
// final stop carries tlast. The serializer emits one symbol per cycle while
// m_tready is high, and the front keeps accepting while a request goes out,
// into a QUEUE_DEPTH-entry queue; a request with a grid number outside the
// range is taken and produces nothing. The display control byte is read
// from the register as frame three goes out, so write it while idle.
module segment_digit_write_serializer #(
    parameter int QUEUE_DEPTH = sdw_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // position[4:0], value[12:5], with_point[13]
    input  logic [1:0]  s_tuser,    // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // bit_value[0]
    output logic [1:0]  m_tuser,    // symbol_kind[1:0]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata   // display_control[7:0]
);

    logic              q_push;
    logic              q_ready;
    logic              q_pop;
    logic              q_valid;
    sdw_pkg::sdw_cmd_t push_cmd;
    sdw_pkg::sdw_cmd_t head_cmd;
    logic [7:0]        display_control_reg;

    // Display control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_control_reg <= sdw_pkg::CTRL_RESET;
        end
        else if (cfg_we)
        begin
            display_control_reg <= cfg_wdata;
        end
    end

    sdw_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    sdw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .not_full  (q_ready),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_cmd  (head_cmd)
    );

    sdw_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_cmd           (head_cmd),
        .q_pop           (q_pop),
        .display_control (display_control_reg),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast)
    );

endmodule

[hw/rtl/sdw_checker.sv]
// ----------------------------------------------------------------------------
// sdw_checker
// Port-level checks on the serializer output stream.
// ----------------------------------------------------------------------------
module sdw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled symbol holds its contents
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output symbol changed while stalled");

    // Start and stop symbols drive the data line low
    a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != sdw_pkg::SYM_BIT) |-> m_tdata == 8'h00)
        else $error("start or stop symbol with data set");

    // The request end is marked only on a stop symbol
    a_last_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == sdw_pkg::SYM_STOP)
        else $error("last flag on a symbol other than stop");

endmodule

bind segment_digit_write_serializer sdw_checker u_sdw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
